### hdl/rrw_pkg.sv
// Shared types, widths, register indexes and codes of the RR window RMSSD unit.
// No dependencies; compile first.
`default_nettype none

package rrw_pkg;

  // Field widths
  localparam int RR_W    = 16;
  localparam int TS_W    = 63;
  localparam int CNT8_W  = 8;
  localparam int RATIO_W = 16;
  localparam int RMS_W   = 16;
  localparam int DATA_W  = 16;
  localparam int IDX_W   = 2;

  // Window depth default and pair threshold
  localparam int WINDOW_DEPTH_DEF = 128;
  localparam int MIN_PAIRS        = 4;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_RR_MIN    = 2'd0;
  localparam logic [IDX_W-1:0] REG_RR_MAX    = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_VALID = 2'd2;

  // Register reset values
  localparam logic [RR_W-1:0]   RR_MIN_RST    = 16'd300;
  localparam logic [RR_W-1:0]   RR_MAX_RST    = 16'd2000;
  localparam logic [CNT8_W-1:0] MIN_VALID_RST = 8'd16;

  // Item modes
  localparam logic MODE_PUSH    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  // Shared arithmetic unit operations
  localparam logic OP_DIV  = 1'b0;
  localparam logic OP_SQRT = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } arith_ctl_t;

endpackage

`default_nettype wire

### hdl/rrw_if.sv
// Valid/ready channels of the RR window RMSSD unit: request and result item.
// Depends on rrw_pkg for field widths.
`default_nettype none

interface rrw_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [rrw_pkg::RR_W-1:0]  rr_ms;
  logic                      wear;
  logic [rrw_pkg::TS_W-1:0]  timestamp_us;

  modport source (output valid, mode, rr_ms, wear, timestamp_us, input ready);
  modport sink   (input valid, mode, rr_ms, wear, timestamp_us, output ready);
endinterface

interface rrw_out_if;
  logic                         valid;
  logic                         ready;
  logic [rrw_pkg::TS_W-1:0]     time_us;
  logic [rrw_pkg::CNT8_W-1:0]   valid_count;
  logic [rrw_pkg::RATIO_W-1:0]  artifact_q15;
  logic [rrw_pkg::RMS_W-1:0]    rmssd;
  logic                         metric_valid;

  modport source (output valid, time_us, valid_count, artifact_q15, rmssd, metric_valid,
                  input ready);
  modport sink   (input valid, time_us, valid_count, artifact_q15, rmssd, metric_valid,
                  output ready);
endinterface

`default_nettype wire

### hdl/rrw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rrw_ram #(
  parameter int WIDTH  = 17,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/rrw_arith.sv
// Shared iterative unit: restoring divide (one quotient bit a cycle) and
// digit-by-digit square root (one root bit a cycle). Depends on rrw_pkg.
`default_nettype none

module rrw_arith #(
  parameter int NUM_W = 50,
  parameter int DEN_W = 8,
  parameter int REM_W = 28
) (
  input  logic                clk,
  input  logic                rst,
  input  rrw_pkg::arith_ctl_t ctl,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output logic                done,
  output logic [NUM_W-1:0]    quo,
  output logic [REM_W-1:0]    rem
);
  import rrw_pkg::*;

  localparam int HALF_W = NUM_W / 2;
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic              op_r;
  logic [STEP_W-1:0] steps;
  logic [NUM_W-1:0]  acc;
  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;
  logic [REM_W:0]    diff;
  logic              fits;

  // One subtractor serves both operations
  always_comb begin
    if (op_r == OP_SQRT) begin
      shifted = {rem[REM_W-3:0], acc[NUM_W-1 -: 2]};
      trial   = {quo[REM_W-3:0], 2'b01};
    end else begin
      shifted = {rem[REM_W-2:0], acc[NUM_W-1]};
      trial   = REM_W'(den);
    end
    diff = {1'b0, shifted} - {1'b0, trial};
    fits = !diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        steps <= (ctl.op == OP_SQRT) ? STEP_W'(HALF_W) : STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_r <= ctl.op;
      acc  <= num;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      acc <= (op_r == OP_SQRT) ? {acc[NUM_W-3:0], 2'b00} : {acc[NUM_W-2:0], 1'b0};
      rem <= fits ? diff[REM_W-1:0] : shifted;
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### hdl/rr_window_rmssd_unit.sv
// RR interval ring window with an RMSSD heart-rate-variability frame.
// Depends on rrw_pkg, rrw_if, rrw_ram and rrw_arith.
// Sequence: a push item is written to the ring when accepted. A compute item walks a non-empty
//   window one entry a cycle, drains the pipeline, then runs the ratio divide, mean divide and
//   root on the shared bit-serial divide/root unit; a frame without a scored RMSSD skips the last two.
// Throughput: one item at a time; ready is high only between items.
// Reset (rst, synchronous): empty window, limits back to 300/2000 ms and 16 intervals.
`default_nettype none

module rr_window_rmssd_unit #(
  parameter int WINDOW_DEPTH = rrw_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rrw_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rrw_pkg::DATA_W-1:0]  cfg_data,
  rrw_in_if.sink                      req,
  rrw_out_if.source                   rsp
);
  import rrw_pkg::*;

  // Sizes that follow from the window depth
  localparam int AW     = $clog2(WINDOW_DEPTH);
  localparam int CW     = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W  = (CW > CNT8_W) ? CW : CNT8_W;
  localparam int SQ_W   = 2 * RR_W;
  localparam int SUM_W  = SQ_W + CW;
  localparam int NUM_W  = 2 * ((SUM_W + 10) / 2);
  localparam int HALF_W = NUM_W / 2;
  localparam int REM_W  = (CW + 2 > HALF_W + 3) ? CW + 2 : HALF_W + 3;
  localparam int ENT_W  = RR_W + 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_RATIO = 3'd3;
  localparam logic [2:0] S_MEAN  = 3'd4;
  localparam logic [2:0] S_ROOT  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]        state;

  // Configuration
  logic [RR_W-1:0]   rr_min;
  logic [RR_W-1:0]   rr_max;
  logic [CNT8_W-1:0] min_valid;

  // Ring bookkeeping
  logic [AW-1:0]     write_slot;
  logic [CW-1:0]     fill_count;

  // Walk pipeline
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     iss_cnt;
  logic              rd_v;
  logic              rd_first;
  logic [ENT_W-1:0]  rdata;
  logic [RR_W-1:0]   prev_rr;
  logic              prev_ok;
  logic              pair_hit;
  logic              diff_v;
  logic [RR_W-1:0]   diff;
  logic              sq_v;
  logic [SQ_W-1:0]   sq;

  // Accumulators and frame
  logic [CW-1:0]     valid_n;
  logic [CW-1:0]     invalid_n;
  logic [CW-1:0]     pair_cnt;
  logic [SUM_W-1:0]  sum;
  logic [TS_W-1:0]   ts_r;
  logic [RATIO_W-1:0] ratio;
  logic [RMS_W-1:0]  rmssd_r;
  logic              metric_r;
  logic              metric_ok;

  // Output register
  logic              rsp_valid;
  logic [TS_W-1:0]   out_time;
  logic [CNT8_W-1:0] out_count;
  logic [RATIO_W-1:0] out_ratio;
  logic [RMS_W-1:0]  out_rmssd;
  logic              out_metric;

  // Push path
  logic              accept;
  logic              push;
  logic              entry_ok;

  // Shared unit
  arith_ctl_t        arith_ctl;
  logic [NUM_W-1:0]  arith_num;
  logic [CW-1:0]     arith_den;
  logic              arith_done;
  logic [NUM_W-1:0]  arith_quo;
  logic [REM_W-1:0]  arith_rem;

  // Rounding and saturation of the root
  logic [HALF_W-1:0] root;
  logic [HALF_W:0]   root_rnd;
  logic [RMS_W-1:0]  root_sat;
  logic [CMP_W-1:0]  vc_ext;
  logic [CNT8_W-1:0] vc_sat;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign push      = accept && (req.mode == MODE_PUSH);
  assign entry_ok  = req.wear && (req.rr_ms >= rr_min) && (req.rr_ms <= rr_max);

  // Ring of intervals; bit RR_W marks a valid interval
  rrw_ram #(
    .WIDTH (ENT_W),
    .DEPTH (WINDOW_DEPTH),
    .ADDR_W(AW)
  ) u_ring (
    .clk  (clk),
    .we   (push),
    .waddr(write_slot),
    .wdata({entry_ok, req.rr_ms}),
    .raddr(rd_ptr),
    .rdata(rdata)
  );

  // A pair counts only when both neighbors are valid and this is not the oldest entry
  assign pair_hit = !rd_first && prev_ok && rdata[RR_W];

  assign metric_ok = (CMP_W'(valid_n) >= CMP_W'(min_valid)) &&
                     (pair_cnt >= CW'(MIN_PAIRS));

  // Operand select follows the state that the start pulse enters
  always_comb begin
    unique case (state)
      S_MEAN: begin
        arith_num = NUM_W'({sum, 8'b0}) + NUM_W'(pair_cnt >> 1);
        arith_den = pair_cnt;
      end
      S_ROOT: begin
        arith_num = arith_quo;
        arith_den = pair_cnt;
      end
      default: begin
        arith_num = NUM_W'({invalid_n, 15'b0}) + NUM_W'(fill_count >> 1);
        arith_den = fill_count;
      end
    endcase
  end

  rrw_arith #(
    .NUM_W(NUM_W),
    .DEN_W(CW),
    .REM_W(REM_W)
  ) u_arith (
    .clk (clk),
    .rst (rst),
    .ctl (arith_ctl),
    .num (arith_num),
    .den (arith_den),
    .done(arith_done),
    .quo (arith_quo),
    .rem (arith_rem)
  );

  // Round to nearest: a remainder above the floor root bumps it; then saturate
  always_comb begin
    root     = arith_quo[HALF_W-1:0];
    root_rnd = {1'b0, root} + (HALF_W+1)'(arith_rem > REM_W'(root));
    root_sat = (root_rnd > (HALF_W+1)'(16'hFFFF)) ? 16'hFFFF : root_rnd[RMS_W-1:0];
    vc_ext   = CMP_W'(valid_n);
    vc_sat   = (vc_ext > CMP_W'(8'hFF)) ? 8'hFF : vc_ext[CNT8_W-1:0];
  end

  // Control: sequencer, ring write slot and fill count, configuration, pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      rr_min     <= RR_MIN_RST;
      rr_max     <= RR_MAX_RST;
      min_valid  <= MIN_VALID_RST;
      rsp_valid  <= 1'b0;
      rd_v       <= 1'b0;
      diff_v     <= 1'b0;
      sq_v       <= 1'b0;
      arith_ctl  <= '0;
    end else begin
      arith_ctl.start <= 1'b0;
      rd_v   <= (state == S_WALK);
      diff_v <= rd_v && pair_hit;
      sq_v   <= diff_v;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_RR_MIN:    rr_min    <= cfg_data;
          REG_RR_MAX:    rr_max    <= cfg_data;
          REG_MIN_VALID: min_valid <= cfg_data[CNT8_W-1:0];
          default: ;
        endcase
      end

      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.mode == MODE_PUSH) begin
              // Advance the write slot, wrap at the window end, saturate the fill
              write_slot <= (write_slot == AW'(WINDOW_DEPTH - 1)) ? '0 : write_slot + AW'(1);
              if (fill_count != CW'(WINDOW_DEPTH)) begin
                fill_count <= fill_count + CW'(1);
              end
            end else if (fill_count == '0) begin
              state <= S_OUT;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (iss_cnt == fill_count - CW'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v && !diff_v && !sq_v) begin
            state     <= S_RATIO;
            arith_ctl <= '{start: 1'b1, op: OP_DIV};
          end
        end
        S_RATIO: begin
          if (arith_done) begin
            if (metric_ok) begin
              state     <= S_MEAN;
              arith_ctl <= '{start: 1'b1, op: OP_DIV};
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_MEAN: begin
          if (arith_done) begin
            state     <= S_ROOT;
            arith_ctl <= '{start: 1'b1, op: OP_SQRT};
          end
        end
        S_ROOT: begin
          if (arith_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold the frame until the output register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: walk from oldest to newest, square, accumulate, collect the frame
  always_ff @(posedge clk) begin
    rd_first <= (iss_cnt == '0);

    if (accept && (req.mode == MODE_COMPUTE)) begin
      ts_r      <= req.timestamp_us;
      valid_n   <= '0;
      invalid_n <= '0;
      pair_cnt  <= '0;
      sum       <= '0;
      ratio     <= '0;
      rmssd_r   <= '0;
      metric_r  <= 1'b0;
      iss_cnt   <= '0;
      // A full ring starts at the oldest slot, the one about to be overwritten
      rd_ptr    <= (fill_count == CW'(WINDOW_DEPTH)) ? write_slot : '0;
    end

    if (state == S_WALK) begin
      rd_ptr  <= (rd_ptr == AW'(WINDOW_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      iss_cnt <= iss_cnt + CW'(1);
    end

    if (rd_v) begin
      if (rdata[RR_W]) begin
        valid_n <= valid_n + CW'(1);
      end else begin
        invalid_n <= invalid_n + CW'(1);
      end
      if (pair_hit) begin
        pair_cnt <= pair_cnt + CW'(1);
      end
      diff    <= (prev_rr > rdata[RR_W-1:0]) ? prev_rr - rdata[RR_W-1:0]
                                             : rdata[RR_W-1:0] - prev_rr;
      prev_rr <= rdata[RR_W-1:0];
      prev_ok <= rdata[RR_W];
    end

    if (diff_v) begin
      sq <= diff * diff;
    end

    if (sq_v) begin
      sum <= sum + SUM_W'(sq);
    end

    if ((state == S_RATIO) && arith_done) begin
      ratio <= arith_quo[RATIO_W-1:0];
    end

    if ((state == S_ROOT) && arith_done) begin
      rmssd_r  <= root_sat;
      metric_r <= 1'b1;
    end

    if ((state == S_OUT) && (!rsp_valid || rsp.ready)) begin
      out_time   <= ts_r;
      out_count  <= vc_sat;
      out_ratio  <= ratio;
      out_rmssd  <= rmssd_r;
      out_metric <= metric_r;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.time_us        = out_time;
  assign rsp.valid_count    = out_count;
  assign rsp.artifact_q15   = out_ratio;
  assign rsp.rmssd          = out_rmssd;
  assign rsp.metric_valid   = out_metric;

  // The fill count never passes the window depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  // A compute item on a non-empty window starts the walk
  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.mode == MODE_COMPUTE) && (fill_count != '0)) |=> (state == S_WALK))
    else $error("compute item did not start the walk");

  // The shared unit finishes only in a state that waits for it
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    arith_done |-> ((state == S_RATIO) || (state == S_MEAN) || (state == S_ROOT)))
    else $error("arith result in unexpected state");

  // Pairs never outnumber valid intervals
  a_pairs: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (pair_cnt <= valid_n))
    else $error("pair count above valid count");

  // The artifact ratio never exceeds one
  a_ratio: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (ratio <= 16'd32768))
    else $error("artifact ratio above one");

endmodule

`default_nettype wire

### tb/rr_window_rmssd_unit_test.sv
// Self-checking bench for rr_window_rmssd_unit: directed and random pushes and frame requests.
// Depends on rrw_pkg, the rrw_in_if/rrw_out_if channels and the unit's RTL; uses no files.
// A built-in window predictor supplies every expected metric frame for comparison.
module rr_window_rmssd_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrw_pkg::*;

  localparam int WIN_DEPTH = WINDOW_DEPTH_DEF;
  // The block does not decode this index, so a write to it must change nothing.
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  // Give a trailing push a margin to settle before any register write.
  localparam int PUSH_SETTLE = 8;
  // Wait at the end long enough for a frame over a full window.
  localparam int FRAME_WAIT = 300;
  localparam int HOLD_CYCLES = 600;
  localparam int STALL_LIMIT = 4000;
  localparam int IDLE_PCT = 27;
  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

  typedef struct packed {
    logic              mode;
    logic [RR_W-1:0]   rr_ms;
    logic              wear;
    logic [TS_W-1:0]   ts;
  } hrv_req_t;

  typedef struct packed {
    logic [TS_W-1:0]    time_us;
    logic [CNT8_W-1:0]  valid_count;
    logic [RATIO_W-1:0] ratio;
    logic [RMS_W-1:0]   rmssd;
    logic               metric_valid;
  } hrv_frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  rrw_in_if  req_ch ();
  rrw_out_if rsp_ch ();

  rr_window_rmssd_unit #(.WINDOW_DEPTH(WIN_DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #4 clk = ~clk;

  // Predictor state: the interval ring, its write slot and fill level, and
  // the register copies. Only the stimulus process touches these.
  logic [RR_W:0]   win_mem [WIN_DEPTH];
  int unsigned     win_wr;
  int unsigned     win_fill;
  logic [RR_W-1:0] lim_lo;
  logic [RR_W-1:0] lim_hi;
  logic [7:0]      need_valid;

  hrv_frame_t pending_frames[$];

  int error_total = 0;
  int items_sent = 0;
  int pushes_sent = 0;
  int frames_checked = 0;
  int frames_scored = 0;
  int frames_saturated = 0;
  int quiet_cycles = 0;

  // Traffic shaping shared with the receiver.
  bit no_idle = 1'b0;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;

  // ---------------------------------------------------------------------------
  // Window predictor
  // ---------------------------------------------------------------------------
  function automatic void window_clear();
    win_wr = 0;
    win_fill = 0;
    lim_lo = RR_MIN_RST;
    lim_hi = RR_MAX_RST;
    need_valid = MIN_VALID_RST;
  endfunction

  // Store the interval with its validity mark: worn and inside the limits.
  function automatic void window_push(input logic [RR_W-1:0] rr, input logic wear);
    logic ok;
    ok = wear && (rr >= lim_lo) && (rr <= lim_hi);
    win_mem[win_wr] = {ok, rr};
    win_wr = (win_wr + 1) % WIN_DEPTH;
    if (win_fill < WIN_DEPTH) win_fill++;
  endfunction

  // The k-th entry counted from the oldest one.
  function automatic logic [RR_W:0] win_entry(input int unsigned k);
    if (win_fill < WIN_DEPTH) return win_mem[k];
    return win_mem[(win_wr + k) % WIN_DEPTH];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic hrv_frame_t window_frame(input logic [TS_W-1:0] ts);
    hrv_frame_t  f;
    int unsigned n_ok;
    int unsigned n_bad;
    int unsigned n_pairs;
    logic [RR_W:0] cur;
    logic [RR_W:0] nxt;
    logic [63:0] d;
    logic [63:0] sq_sum;
    logic [63:0] mean;
    logic [63:0] root;
    f = '0;
    f.time_us = ts;
    n_ok = 0;
    n_bad = 0;
    n_pairs = 0;
    sq_sum = '0;
    // Empty window: only the timestamp is carried.
    if (win_fill == 0) return f;
    for (int unsigned k = 0; k < win_fill; k++) begin
      cur = win_entry(k);
      if (cur[RR_W]) n_ok++;
      else n_bad++;
      if (k + 1 < win_fill) begin
        nxt = win_entry(k + 1);
        if (cur[RR_W] && nxt[RR_W]) begin
          d = (cur[RR_W-1:0] > nxt[RR_W-1:0]) ? 64'(cur[RR_W-1:0] - nxt[RR_W-1:0])
                                               : 64'(nxt[RR_W-1:0] - cur[RR_W-1:0]);
          sq_sum += d * d;
          n_pairs++;
        end
      end
    end
    f.valid_count = (n_ok > 255) ? 8'd255 : 8'(n_ok);
    f.ratio = RATIO_W'(((64'(n_bad) << 15) + 64'(win_fill / 2)) / 64'(win_fill));
    // Score RMSSD only with enough valid intervals and enough valid pairs.
    if (n_ok >= need_valid && n_pairs >= MIN_PAIRS) begin
      mean = ((sq_sum << 8) + 64'(n_pairs / 2)) / 64'(n_pairs);
      root = floor_sqrt(mean);
      if (mean - root * root > root) root++;
      if (root > 64'd65535) root = 64'd65535;
      f.rmssd = RMS_W'(root);
      f.metric_valid = 1'b1;
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders and channel drivers
  // ---------------------------------------------------------------------------
  function automatic hrv_req_t push_item(input logic [RR_W-1:0] rr, input logic wear);
    hrv_req_t it;
    it = '0;
    it.mode = MODE_PUSH;
    it.rr_ms = rr;
    it.wear = wear;
    it.ts = TS_W'({$urandom, $urandom});
    return it;
  endfunction

  function automatic hrv_req_t frame_item(input logic [TS_W-1:0] ts);
    hrv_req_t it;
    it = '0;
    it.mode = MODE_COMPUTE;
    it.rr_ms = RR_W'($urandom);
    it.wear = 1'($urandom);
    it.ts = ts;
    return it;
  endfunction

  // Offer one item, hold it until the block takes it, then predict its effect.
  // Valid stays high after acceptance until the next call idles or replaces the item, or wait_idle drops it.
  task automatic send_item(input hrv_req_t it);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= it.mode;
    req_ch.rr_ms        <= it.rr_ms;
    req_ch.wear         <= it.wear;
    req_ch.timestamp_us <= it.ts;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    if (it.mode == MODE_PUSH) begin
      pushes_sent++;
      window_push(it.rr_ms, it.wear);
    end else begin
      pending_frames.push_back(window_frame(it.ts));
    end
  endtask

  // Drop valid, wait for every expected frame, then let a trailing push settle.
  task automatic wait_idle(input int settle);
    req_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write one register; call only while the block is idle.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RR_MIN:    lim_lo = data;
      REG_RR_MAX:    lim_hi = data;
      REG_MIN_VALID: need_valid = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [RR_W-1:0] lo, input logic [RR_W-1:0] hi,
                            input logic [7:0] need);
    write_reg(REG_RR_MIN, lo);
    write_reg(REG_RR_MAX, hi);
    write_reg(REG_MIN_VALID, DATA_W'(need));
  endtask

  // One random phase: mostly plausible intervals, some noise, frames now and then.
  task automatic run_phase(input int count, input int noise_pct, input int frame_pct);
    logic [RR_W-1:0] rr;
    logic wear;
    int pick;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < frame_pct) begin
        send_item(frame_item(TS_W'({$urandom, $urandom})));
      end else begin
        if ($urandom_range(99) < noise_pct || lim_lo > lim_hi) begin
          rr = RR_W'($urandom);
          wear = 1'($urandom);
        end else begin
          pick = $urandom_range(99);
          wear = ($urandom_range(99) < 97);
          if (pick < 5) rr = lim_lo;
          else if (pick < 10) rr = lim_hi;
          else rr = RR_W'($urandom_range(int'(lim_hi), int'(lim_lo)));
        end
        send_item(push_item(rr, wear));
      end
    end
    wait_idle(PUSH_SETTLE);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver idling
  // ---------------------------------------------------------------------------
  task automatic check_frame();
    hrv_frame_t got;
    hrv_frame_t exp;
    got.time_us      = rsp_ch.time_us;
    got.valid_count  = rsp_ch.valid_count;
    got.ratio        = rsp_ch.artifact_q15;
    got.rmssd        = rsp_ch.rmssd;
    got.metric_valid = rsp_ch.metric_valid;
    if (pending_frames.size() == 0) begin
      error_total++;
      if (error_total <= 10)
        $display("[%0t] unexpected frame: time %0h count %0d ratio %0d rmssd %0d ok %0b",
                 $realtime, got.time_us, got.valid_count, got.ratio, got.rmssd,
                 got.metric_valid);
    end else begin
      exp = pending_frames.pop_front();
      frames_checked++;
      if (exp.metric_valid) frames_scored++;
      if (exp.rmssd == 16'hFFFF) frames_saturated++;
      if (got.time_us !== exp.time_us || got.valid_count !== exp.valid_count ||
          got.ratio !== exp.ratio || got.rmssd !== exp.rmssd ||
          got.metric_valid !== exp.metric_valid) begin
        error_total++;
        if (error_total <= 10) begin
          $display("[%0t] frame mismatch, expected: time %0h count %0d ratio %0d rmssd %0d ok %0b",
                   $realtime, exp.time_us, exp.valid_count, exp.ratio, exp.rmssd,
                   exp.metric_valid);
          $display("           actual:   time %0h count %0d ratio %0d rmssd %0d ok %0b",
                   got.time_us, got.valid_count, got.ratio, got.rmssd, got.metric_valid);
        end
      end
    end
  endtask

  // Check every accepted frame, then pick ready for the next edge. A new hold
  // ticket starts a long stall so that the block fills up and blocks its input.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) check_frame();
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (hold_ticket != hold_served) begin
        hold_served <= hold_ticket;
        hold_left <= HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // End the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // An empty window returns only the timestamp; try both timestamp extremes.
  task automatic test_empty_window();
    send_item(frame_item('0));
    send_item(frame_item(TS_MAX));
    wait_idle(PUSH_SETTLE);
  endtask

  // Full-range limits and no count requirement: alternate 0 and 65535 so that
  // four pairs score and the root saturates, then add an unworn interval.
  task automatic test_field_extremes();
    set_limits(16'd0, 16'hFFFF, 8'd0);
    send_item(push_item(16'd0, 1'b1));
    send_item(push_item(16'hFFFF, 1'b1));
    send_item(push_item(16'd0, 1'b1));
    send_item(push_item(16'hFFFF, 1'b1));
    send_item(push_item(16'd0, 1'b1));
    send_item(frame_item(TS_MAX));
    send_item(push_item(16'hFFFF, 1'b0));
    send_item(frame_item(63'h2AAA_AAAA_AAAA_AAAA));
    wait_idle(PUSH_SETTLE);
  endtask

  // Limit edges, too few valid intervals, inverted limits and an unused index.
  task automatic test_limit_edges();
    set_limits(RR_MIN_RST, RR_MAX_RST, 8'd128);
    send_item(push_item(RR_MIN_RST - 16'd1, 1'b1));
    send_item(push_item(RR_MIN_RST, 1'b1));
    send_item(push_item(RR_MAX_RST, 1'b1));
    send_item(push_item(RR_MAX_RST + 16'd1, 1'b1));
    send_item(push_item(16'd1000, 1'b0));
    send_item(frame_item(63'h5555_5555_5555_5555));
    wait_idle(PUSH_SETTLE);
    // Inverted limits mark everything invalid; the unused index must not disturb them.
    set_limits(RR_MAX_RST, RR_MIN_RST, 8'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_item(push_item(16'd1000, 1'b1));
    send_item(frame_item(63'd1));
    wait_idle(PUSH_SETTLE);
  endtask

  // Random traffic under default, full-range and narrow settings; the
  // full-range phase runs with no idling on either side.
  task automatic test_random_traffic();
    set_limits(RR_MIN_RST, RR_MAX_RST, MIN_VALID_RST);
    run_phase(60, 15, 15);
    set_limits(16'd0, 16'hFFFF, 8'd0);
    no_idle = 1'b1;
    run_phase(60, 20, 15);
    no_idle = 1'b0;
    set_limits(16'd400, 16'd1600, 8'd4);
    run_phase(60, 10, 15);
  endtask

  // Inverted limits while the receiver stalls for a long stretch.
  task automatic test_output_stall();
    set_limits(16'hFFFF, 16'd0, 8'd8);
    hold_ticket <= hold_ticket + 1;
    run_phase(60, 30, 15);
  endtask

  // Clean intervals long enough to wrap the ring and meet the largest count.
  task automatic test_full_window();
    set_limits(16'd500, 16'd1500, 8'd128);
    run_phase(200, 0, 8);
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_PUSH;
    req_ch.rr_ms = '0;
    req_ch.wear = 1'b0;
    req_ch.timestamp_us = '0;
    window_clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_window();
    test_field_extremes();
    test_limit_edges();
    test_random_traffic();
    test_output_stall();
    test_full_window();

    wait_idle(FRAME_WAIT);
    if (pending_frames.size() != 0) begin
      error_total += pending_frames.size();
      $display("%0d expected frames never arrived", pending_frames.size());
    end
    $display("Covered %0d items (%0d pushes) and %0d frames; %0d scored, %0d saturated.",
             items_sent, pushes_sent, frames_checked, frames_scored, frames_saturated);
    $display("Settings: reset, full-range, narrow, inverted and full-window limits, output stall.");
    if (error_total == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
